FILE: design/fpps_pkg.sv
// fpps_pkg: shared constants, codes and types of the periodic task scheduler
// used by fpps_ctrl, fpps_datapath and the top level; no dependencies

package fpps_pkg;

  localparam int MAX_SLOTS = 16;
  localparam int IDX_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
  localparam int CMP_W     = 7;
  localparam int ACT_W     = 3;
  localparam int SLOT_W    = 6;

  localparam logic [7:0] PRIO_LIMIT = 8'd250;

  localparam logic [ACT_W-1:0] ACT_ADD      = 3'd0;
  localparam logic [ACT_W-1:0] ACT_TICK     = 3'd1;
  localparam logic [ACT_W-1:0] ACT_DISPATCH = 3'd2;
  localparam logic [ACT_W-1:0] ACT_COMPLETE = 3'd3;
  localparam logic [ACT_W-1:0] ACT_READ     = 3'd4;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_FULL = 2'd1;
  localparam logic [1:0] STAT_NONE = 2'd2;
  localparam logic [1:0] STAT_BAD  = 2'd3;

  localparam logic [1:0] TS_BLOCKED = 2'd0;
  localparam logic [1:0] TS_READY   = 2'd1;
  localparam logic [1:0] TS_RUNNING = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_ADD,
    OP_TICK_STEP,
    OP_TICK_DONE,
    OP_SCAN_STEP,
    OP_PICK,
    OP_COMPLETE,
    OP_LOAD_OUT
  } dp_op_t;

  typedef enum logic [2:0] {
    ADDR_HOLD,
    ADDR_USED,
    ADDR_RUN,
    ADDR_SLOT,
    ADDR_PICK
  } addr_sel_t;

  typedef struct packed {
    dp_op_t     op;
    addr_sel_t  addr_sel;
    logic [1:0] rep_status;
    logic       rep_zero;
  } dp_cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             table_full;
    logic             running_valid;
    logic             walk_end;
    logic             found;
    logic             slot_bad;
  } dp_sts_t;

endpackage

FILE: design/fpps_ctrl.sv
// fpps_ctrl: sequencer of the scheduler, one request at a time
// depends on fpps_pkg for command and status types and codes

module fpps_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  fpps_pkg::dp_sts_t sts,
  output fpps_pkg::dp_cmd_t cmd
);
  import fpps_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_TICK,
    S_SCAN,
    S_PICK,
    S_COMPLETE,
    S_REPORT
  } state_t;

  state_t     state, state_next;
  logic       out_valid_next;
  logic [1:0] rep_status, rep_status_next;
  logic       rep_zero, rep_zero_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next      = state;
    out_valid_next  = out_valid && !out_ready;
    rep_status_next = rep_status;
    rep_zero_next   = rep_zero;
    cmd.op          = OP_NONE;
    cmd.addr_sel    = ADDR_HOLD;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LATCH;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next      = S_REPORT;
        rep_status_next = STAT_OK;
        rep_zero_next   = 1'b0;
        case (sts.act)
          ACT_ADD: begin
            if (sts.table_full) begin
              rep_status_next = STAT_FULL;
              rep_zero_next   = 1'b1;
            end else begin
              cmd.op       = OP_ADD;
              cmd.addr_sel = ADDR_USED;
            end
          end
          ACT_TICK: begin
            state_next = S_TICK;
          end
          ACT_DISPATCH: begin
            if (sts.running_valid) begin
              cmd.addr_sel = ADDR_RUN;
            end else begin
              state_next = S_SCAN;
            end
          end
          ACT_COMPLETE: begin
            if (sts.running_valid) begin
              cmd.addr_sel = ADDR_RUN;
              state_next   = S_COMPLETE;
            end else begin
              rep_status_next = STAT_NONE;
              rep_zero_next   = 1'b1;
            end
          end
          ACT_READ: begin
            if (sts.slot_bad) begin
              rep_status_next = STAT_BAD;
              rep_zero_next   = 1'b1;
            end else begin
              cmd.addr_sel = ADDR_SLOT;
            end
          end
          default: begin
            rep_zero_next = 1'b1;
          end
        endcase
      end
      S_TICK: begin
        if (sts.walk_end) begin
          cmd.op          = OP_TICK_DONE;
          rep_status_next = STAT_OK;
          rep_zero_next   = 1'b1;
          state_next      = S_REPORT;
        end else begin
          cmd.op = OP_TICK_STEP;
        end
      end
      S_SCAN: begin
        if (sts.walk_end) begin
          if (sts.found) begin
            cmd.addr_sel = ADDR_PICK;
            state_next   = S_PICK;
          end else begin
            rep_status_next = STAT_NONE;
            rep_zero_next   = 1'b1;
            state_next      = S_REPORT;
          end
        end else begin
          cmd.op = OP_SCAN_STEP;
        end
      end
      S_PICK: begin
        cmd.op     = OP_PICK;
        state_next = S_REPORT;
      end
      S_COMPLETE: begin
        cmd.op     = OP_COMPLETE;
        state_next = S_REPORT;
      end
      S_REPORT: begin
        if (!out_valid || out_ready) begin
          cmd.op         = OP_LOAD_OUT;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    cmd.rep_status = rep_status;
    cmd.rep_zero   = rep_zero;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      rep_status <= STAT_OK;
      rep_zero   <= 1'b1;
    end else begin
      state      <= state_next;
      out_valid  <= out_valid_next;
      rep_status <= rep_status_next;
      rep_zero   <= rep_zero_next;
    end
  end

endmodule

FILE: design/fpps_datapath.sv
// fpps_datapath: task table, tick counter, scan registers and result register
// depends on fpps_pkg; driven by fpps_ctrl through dp_cmd_t

module fpps_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  fpps_pkg::dp_cmd_t         cmd,
  output fpps_pkg::dp_sts_t         sts,
  input  logic [fpps_pkg::ACT_W-1:0]  action,
  input  logic [15:0]               period_ticks,
  input  logic [7:0]                prio,
  input  logic [fpps_pkg::SLOT_W-1:0] slot,
  input  logic                      gate_open,
  input  logic                      cfg_we,
  input  logic [fpps_pkg::SLOT_W-1:0] cfg_wdata,
  output logic [1:0]                status,
  output logic [fpps_pkg::SLOT_W-1:0] chosen_slot,
  output logic [1:0]                slot_state,
  output logic [7:0]                pending_jobs,
  output logic [7:0]                peak_pending,
  output logic [15:0]               release_count,
  output logic [15:0]               run_count,
  output logic [15:0]               miss_count
);
  import fpps_pkg::*;

  typedef struct packed {
    logic [15:0] period;
    logic [31:0] next_rel;
    logic [7:0]  prio;
    logic [7:0]  pending;
    logic [7:0]  peak;
    logic [15:0] rel;
    logic [15:0] run;
    logic [15:0] miss;
    logic [1:0]  tstate;
  } entry_t;

  entry_t tbl [MAX_SLOTS];

  logic [31:0]       tick_count;
  logic [CNT_W-1:0]  slots_used;
  logic [IDX_W-1:0]  running_slot;
  logic              running_valid;
  logic [SLOT_W-1:0] gated_slot;
  logic [CNT_W-1:0]  cursor;
  logic [IDX_W-1:0]  addr;
  logic [IDX_W-1:0]  pick;
  logic [7:0]        best;
  logic              found;

  logic [ACT_W-1:0]  act_q;
  logic [15:0]       period_q;
  logic [7:0]        prio_q;
  logic [SLOT_W-1:0] slot_q;
  logic              gate_q;

  logic [IDX_W-1:0]  rd_idx;
  entry_t            rd;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_idx;
  entry_t            wr_data;

  function automatic logic [15:0] sat16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  assign rd_idx = (cmd.op == OP_TICK_STEP || cmd.op == OP_SCAN_STEP) ?
                  cursor[IDX_W-1:0] : addr;
  assign rd     = tbl[rd_idx];

  assign sts.act           = act_q;
  assign sts.table_full    = (slots_used >= CNT_W'(MAX_SLOTS));
  assign sts.running_valid = running_valid;
  assign sts.walk_end      = (cursor >= slots_used);
  assign sts.found         = found;
  assign sts.slot_bad      = (CMP_W'(slot_q) >= CMP_W'(slots_used));

  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = addr;
    wr_data = rd;
    case (cmd.op)
      OP_ADD: begin
        wr_en            = 1'b1;
        wr_idx           = slots_used[IDX_W-1:0];
        wr_data.period   = period_q;
        wr_data.next_rel = 32'(period_q);
        wr_data.prio     = prio_q;
        wr_data.pending  = 8'd1;
        wr_data.peak     = 8'd1;
        wr_data.rel      = 16'd0;
        wr_data.run      = 16'd0;
        wr_data.miss     = 16'd0;
        wr_data.tstate   = TS_READY;
      end
      OP_TICK_STEP: begin
        wr_en  = 1'b1;
        wr_idx = cursor[IDX_W-1:0];
        if (rd.next_rel == tick_count) begin
          wr_data.rel = sat16(rd.rel);
          if (rd.tstate != TS_BLOCKED) begin
            wr_data.miss = sat16(rd.miss);
          end
          wr_data.tstate   = TS_READY;
          wr_data.next_rel = rd.next_rel + 32'(rd.period);
          wr_data.pending  = (rd.pending != 8'hFF) ? rd.pending + 8'd1 : rd.pending;
          if (wr_data.pending > rd.peak) begin
            wr_data.peak = wr_data.pending;
          end
        end
        if ((SLOT_W'(cursor) == gated_slot) && !gate_q) begin
          wr_data.tstate = TS_BLOCKED;
        end
      end
      OP_PICK: begin
        wr_en          = 1'b1;
        wr_data.tstate = TS_RUNNING;
      end
      OP_COMPLETE: begin
        wr_en           = 1'b1;
        wr_data.run     = sat16(rd.run);
        wr_data.pending = (rd.pending != 8'd0) ? rd.pending - 8'd1 : rd.pending;
        wr_data.tstate  = (wr_data.pending != 8'd0) ? TS_READY : TS_BLOCKED;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tbl[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count    <= '0;
      slots_used    <= '0;
      running_slot  <= '0;
      running_valid <= 1'b0;
      gated_slot    <= '1;
      cursor        <= '0;
      found         <= 1'b0;
    end else begin
      if (cfg_we) begin
        gated_slot <= cfg_wdata;
      end
      case (cmd.op)
        OP_LATCH: begin
          cursor <= '0;
          found  <= 1'b0;
        end
        OP_ADD: begin
          slots_used <= slots_used + CNT_W'(1);
        end
        OP_TICK_STEP: begin
          cursor <= cursor + CNT_W'(1);
        end
        OP_TICK_DONE: begin
          tick_count <= tick_count + 32'd1;
        end
        OP_SCAN_STEP: begin
          cursor <= cursor + CNT_W'(1);
          if (rd.tstate == TS_READY && rd.prio < best) begin
            found <= 1'b1;
          end
        end
        OP_PICK: begin
          running_slot  <= addr;
          running_valid <= 1'b1;
        end
        OP_COMPLETE: begin
          running_valid <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // item registers, scan candidate, table address and result payload
  always_ff @(posedge clk) begin
    case (cmd.addr_sel)
      ADDR_USED: addr <= slots_used[IDX_W-1:0];
      ADDR_RUN:  addr <= running_slot;
      ADDR_SLOT: addr <= slot_q[IDX_W-1:0];
      ADDR_PICK: addr <= pick;
      default:   addr <= addr;
    endcase
    if (cmd.op == OP_LATCH) begin
      act_q    <= action;
      period_q <= period_ticks;
      prio_q   <= prio;
      slot_q   <= slot;
      gate_q   <= gate_open;
      best     <= PRIO_LIMIT + 8'd1;
    end
    if (cmd.op == OP_SCAN_STEP && rd.tstate == TS_READY && rd.prio < best) begin
      best <= rd.prio;
      pick <= cursor[IDX_W-1:0];
    end
    if (cmd.op == OP_LOAD_OUT) begin
      status <= cmd.rep_status;
      if (cmd.rep_zero) begin
        chosen_slot   <= '0;
        slot_state    <= '0;
        pending_jobs  <= '0;
        peak_pending  <= '0;
        release_count <= '0;
        run_count     <= '0;
        miss_count    <= '0;
      end else begin
        chosen_slot   <= SLOT_W'(addr);
        slot_state    <= rd.tstate;
        pending_jobs  <= rd.pending;
        peak_pending  <= rd.peak;
        release_count <= rd.rel;
        run_count     <= rd.run;
        miss_count    <= rd.miss;
      end
    end
  end

endmodule

FILE: design/fixed_priority_periodic_scheduler.sv
// fixed_priority_periodic_scheduler: top level of the periodic task scheduler
// instantiates fpps_ctrl and fpps_datapath; depends on fpps_pkg
//
// usage
//   request channel in_valid/in_ready carries action, period_ticks, prio, slot
//   and gate_open; one result per request leaves on out_valid/out_ready.
//   cfg_we/cfg_wdata write gated_slot at once; write it only while idle.
// timing
//   one request at a time, taken only in the idle state; out_valid rises in
//   the same cycle as the return to idle, when the next request can be taken.
//   add, read, unknown and dispatch with a task running pass idle, decode and
//   report; complete with a task running adds a complete step; tick, and
//   dispatch with none running, walk the table; a found task gets a pick step.
// reset
//   rst clears tick count, slot count, running task and result valid and sets
//   gated_slot to 63; table entries are undefined until a task is added.
// stall
//   the result sits in an output register; the next request is taken while it
//   waits, and that request finishes up to its report step and holds there
//   until out_ready frees the register.

module fixed_priority_periodic_scheduler (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  action,
  input  logic [15:0] period_ticks,
  input  logic [7:0]  prio,
  input  logic [5:0]  slot,
  input  logic        gate_open,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_wdata,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [5:0]  chosen_slot,
  output logic [1:0]  slot_state,
  output logic [7:0]  pending_jobs,
  output logic [7:0]  peak_pending,
  output logic [15:0] release_count,
  output logic [15:0] run_count,
  output logic [15:0] miss_count
);
  import fpps_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  fpps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fpps_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .action        (action),
    .period_ticks  (period_ticks),
    .prio          (prio),
    .slot          (slot),
    .gate_open     (gate_open),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .status        (status),
    .chosen_slot   (chosen_slot),
    .slot_state    (slot_state),
    .pending_jobs  (pending_jobs),
    .peak_pending  (peak_pending),
    .release_count (release_count),
    .run_count     (run_count),
    .miss_count    (miss_count)
  );

endmodule
